[rtl/clbs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_pkg
// Shared types, command codes and the power-on init step table of the
// character LCD bus sequencer.
// ----------------------------------------------------------------------------
package clbs_pkg;

    // request codes; codes 6 and 7 are unused and emit nothing
    typedef enum logic [2:0] {
        OP_INIT  = 3'd0,
        OP_CMD   = 3'd1,
        OP_DATA  = 3'd2,
        OP_GOTO  = 3'd3,
        OP_CLEAR = 3'd4,
        OP_GLYPH = 3'd5
    } t_opcode;

    // configuration register indexes
    localparam logic CFG_BUS_MODE    = 1'b0;
    localparam logic CFG_STROBE_HOLD = 1'b1;

    localparam logic       BUS_MODE_RST     = 1'b1;
    localparam logic [7:0] STROBE_HOLD_RST  = 8'd2;

    // controller commands
    localparam logic [7:0] LCD_FUNC_8BIT = 8'h38;
    localparam logic [7:0] LCD_FUNC_4BIT = 8'h28;
    localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
    localparam logic [7:0] LCD_ERASE     = 8'h01;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;
    localparam logic [7:0] LCD_ROW0      = 8'h80;
    localparam logic [7:0] LCD_ROW1      = 8'hC0;
    localparam logic [7:0] LCD_CGRAM     = 8'h40;
    localparam logic [7:0] LCD_HOME      = 8'h02;

    // pause lengths in ms
    localparam logic [7:0] DLY_POWER_ON = 8'd50;
    localparam logic [7:0] DLY_SHORT    = 8'd1;
    localparam logic [7:0] DLY_CLEAR    = 8'd20;

    localparam int unsigned STEP_IDX_W = 4;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // one sequence step: a pause (val = ms) or a byte transfer (val = byte)
    typedef struct packed {
        logic       is_delay;
        logic [7:0] val;
        logic       last;
    } t_step;

    typedef struct packed {
        logic  load;
        logic  emit;
        t_step step;
        logic  use_req;
        logic  nibble;
        logic  en_hi;
        logic  last;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
        logic four_bit;
        logic req_emits;
        logic req_is_init;
    } t_dp_stat;

    function automatic t_step mk_delay(input logic [7:0] ms);
        t_step s;
        s.is_delay = 1'b1;
        s.val      = ms;
        s.last     = 1'b0;
        return s;
    endfunction

    function automatic t_step mk_byte(input logic [7:0] b, input logic last);
        t_step s;
        s.is_delay = 1'b0;
        s.val      = b;
        s.last     = last;
        return s;
    endfunction

    function automatic t_step init_step(input logic four_bit,
                                        input logic [STEP_IDX_W-1:0] idx);
        t_step s;
        s = mk_delay(DLY_POWER_ON);
        if (four_bit) begin
            case (idx)
                4'd0:    s = mk_delay(DLY_POWER_ON);
                4'd1:    s = mk_byte(LCD_HOME, 1'b0);
                4'd2:    s = mk_delay(DLY_SHORT);
                4'd3:    s = mk_byte(LCD_FUNC_4BIT, 1'b0);
                4'd4:    s = mk_delay(DLY_SHORT);
                4'd5:    s = mk_byte(LCD_DISP_ON, 1'b0);
                4'd6:    s = mk_delay(DLY_SHORT);
                4'd7:    s = mk_byte(LCD_ERASE, 1'b0);
                4'd8:    s = mk_delay(DLY_CLEAR);
                4'd9:    s = mk_byte(LCD_ENTRY, 1'b0);
                4'd10:   s = mk_byte(LCD_ROW0, 1'b1);
                default: s = mk_byte(LCD_ROW0, 1'b1);
            endcase
        end else begin
            case (idx)
                4'd0:    s = mk_delay(DLY_POWER_ON);
                4'd1:    s = mk_byte(LCD_FUNC_8BIT, 1'b0);
                4'd2:    s = mk_delay(DLY_SHORT);
                4'd3:    s = mk_byte(LCD_DISP_ON, 1'b0);
                4'd4:    s = mk_delay(DLY_SHORT);
                4'd5:    s = mk_byte(LCD_ERASE, 1'b0);
                4'd6:    s = mk_delay(DLY_CLEAR);
                4'd7:    s = mk_byte(LCD_ENTRY, 1'b0);
                4'd8:    s = mk_byte(LCD_ROW0, 1'b1);
                default: s = mk_byte(LCD_ROW0, 1'b1);
            endcase
        end
        return s;
    endfunction

endpackage
`default_nettype wire

[rtl/clbs_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clbs request and pin-state channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface clbs_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] value;
    logic [1:0] line;
    logic [5:0] column;
    logic [2:0] glyph_slot;

    modport source (output valid, opcode, value, line, column, glyph_slot, input ready);
    modport sink   (input valid, opcode, value, line, column, glyph_slot, output ready);
endinterface

interface clbs_pin_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [7:0] bus_value;
    logic       enable_level;
    logic [7:0] hold_ms;
    logic       last;

    modport source (output valid, reg_select, bus_value, enable_level, hold_ms, last,
                    input ready);
    modport sink   (input valid, reg_select, bus_value, enable_level, hold_ms, last,
                    output ready);
endinterface
`default_nettype wire

[rtl/clbs_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_datapath
// Configuration, request capture, driven pin state and the pin-state output
// register of the LCD bus sequencer.
// ----------------------------------------------------------------------------
module clbs_datapath (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_idx,
    input  wire  [7:0]           i_cfg_wdata,
    input  clbs_pkg::t_ctl_cmd   i_cmd,
    output clbs_pkg::t_dp_stat   o_stat,
    input  wire  [2:0]           i_opcode,
    input  wire  [7:0]           i_value,
    input  wire  [1:0]           i_line,
    input  wire  [5:0]           i_column,
    input  wire  [2:0]           i_glyph_slot,
    input  wire                  i_pin_ready,
    output logic                 o_pin_valid,
    output logic                 o_reg_select,
    output logic [7:0]           o_bus_value,
    output logic                 o_enable_level,
    output logic [7:0]           o_hold_ms,
    output logic                 o_last
);
    import clbs_pkg::*;

    logic       r_bus_mode;
    logic [7:0] r_strobe_hold;
    logic       r_drv_sel;
    logic [7:0] r_drv_bus;
    logic       r_req_rs;
    logic [7:0] r_req_byte;
    logic       r_out_vld;
    logic       r_out_rs;
    logic [7:0] r_out_bus;
    logic       r_out_en;
    logic [7:0] r_out_hold;
    logic       r_out_last;

    logic       n_req_rs;
    logic [7:0] n_req_byte;
    logic       req_emits;
    logic [7:0] byte_sel;
    logic       rs_sel;
    logic [7:0] bus_sel;

    // decode the request into the single byte it sends; init runs the step table instead
    always_comb begin
        n_req_rs   = 1'b0;
        n_req_byte = '0;
        req_emits  = 1'b0;
        case (t_opcode'(i_opcode))
            OP_INIT: begin
                req_emits = 1'b1;
            end
            OP_CMD: begin
                req_emits  = 1'b1;
                n_req_byte = i_value;
            end
            OP_DATA: begin
                req_emits  = 1'b1;
                n_req_rs   = 1'b1;
                n_req_byte = i_value;
            end
            OP_GOTO: begin
                // rows above 1 or columns above 15 are dropped
                req_emits  = (i_column[5:4] == 2'b00) && !i_line[1];
                n_req_byte = (i_line[0] ? LCD_ROW1 : LCD_ROW0) | {4'b0000, i_column[3:0]};
            end
            OP_CLEAR: begin
                req_emits  = 1'b1;
                n_req_byte = LCD_ERASE;
            end
            OP_GLYPH: begin
                req_emits  = 1'b1;
                n_req_byte = LCD_CGRAM | {2'b00, i_glyph_slot, 3'b000};
            end
            default: begin
                req_emits = 1'b0;
            end
        endcase
    end

    always_comb begin
        byte_sel = i_cmd.use_req ? r_req_byte : i_cmd.step.val;
        rs_sel   = i_cmd.use_req ? r_req_rs : 1'b0;
        if (r_bus_mode) begin
            bus_sel = i_cmd.nibble ? {byte_sel[3:0], 4'b0000} : {byte_sel[7:4], 4'b0000};
        end else begin
            bus_sel = byte_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_mode    <= BUS_MODE_RST;
            r_strobe_hold <= STROBE_HOLD_RST;
            r_drv_sel     <= 1'b0;
            r_drv_bus     <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BUS_MODE:    r_bus_mode    <= i_cfg_wdata[0];
                    CFG_STROBE_HOLD: r_strobe_hold <= i_cfg_wdata;
                    default:         r_bus_mode    <= r_bus_mode;
                endcase
            end
            if (i_cmd.emit && !i_cmd.step.is_delay) begin
                r_drv_sel <= rs_sel;
                r_drv_bus <= bus_sel;
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_pin_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_rs   <= n_req_rs;
            r_req_byte <= n_req_byte;
        end
        if (i_cmd.emit) begin
            r_out_last <= i_cmd.last;
            if (i_cmd.step.is_delay) begin
                // pause: repeat the last driven pins with enable low
                r_out_rs   <= r_drv_sel;
                r_out_bus  <= r_drv_bus;
                r_out_en   <= 1'b0;
                r_out_hold <= i_cmd.step.val;
            end else begin
                r_out_rs   <= rs_sel;
                r_out_bus  <= bus_sel;
                r_out_en   <= i_cmd.en_hi;
                r_out_hold <= r_strobe_hold;
            end
        end
    end

    always_comb begin
        o_stat.out_free    = !r_out_vld || i_pin_ready;
        o_stat.four_bit    = r_bus_mode;
        o_stat.req_emits   = req_emits;
        o_stat.req_is_init = (t_opcode'(i_opcode) == OP_INIT);
    end

    assign o_pin_valid    = r_out_vld;
    assign o_reg_select   = r_out_rs;
    assign o_bus_value    = r_out_bus;
    assign o_enable_level = r_out_en;
    assign o_hold_ms      = r_out_hold;
    assign o_last         = r_out_last;

endmodule
`default_nettype wire

[rtl/clbs_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_ctrl
// Sequencer state machine: walks the init steps or a single byte, and the
// nibble and enable phases of each byte, one pin state per cycle while the output is free.
// ----------------------------------------------------------------------------
module clbs_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    output logic                o_req_ready,
    input  clbs_pkg::t_dp_stat  i_stat,
    output clbs_pkg::t_ctl_cmd  o_cmd
);
    import clbs_pkg::*;

    t_state                r_state, n_state;
    logic                  r_init, n_init;
    logic [STEP_IDX_W-1:0] r_idx, n_idx;
    logic                  r_nibble, n_nibble;
    logic                  r_en_lo, n_en_lo;
    t_step                 step;
    logic                  byte_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_init   <= 1'b0;
            r_idx    <= '0;
            r_nibble <= 1'b0;
            r_en_lo  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_idx    <= n_idx;
            r_nibble <= n_nibble;
            r_en_lo  <= n_en_lo;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_idx       = r_idx;
        n_nibble    = r_nibble;
        n_en_lo     = r_en_lo;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        step        = r_init ? init_step(i_stat.four_bit, r_idx) : mk_byte(8'h00, 1'b1);
        byte_done   = r_en_lo && (!i_stat.four_bit || r_nibble);

        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.req_emits) begin
                        n_state  = ST_RUN;
                        n_init   = i_stat.req_is_init;
                        n_idx    = '0;
                        n_nibble = 1'b0;
                        n_en_lo  = 1'b0;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.step    = step;
                o_cmd.use_req = !r_init;
                o_cmd.nibble  = r_nibble;
                o_cmd.en_hi   = !r_en_lo;
                o_cmd.last    = step.last && (step.is_delay || byte_done);
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (step.is_delay) begin
                        n_idx = r_idx + 1'b1;
                    end else if (!r_en_lo) begin
                        n_en_lo = 1'b1;
                    end else if (!byte_done) begin
                        // advance to the low nibble
                        n_en_lo  = 1'b0;
                        n_nibble = 1'b1;
                    end else begin
                        n_en_lo  = 1'b0;
                        n_nibble = 1'b0;
                        n_idx    = r_idx + 1'b1;
                    end
                    if (o_cmd.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_load_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !o_cmd.load)
        else $error("request taken while a run is in progress");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("pin state emitted over an untaken one");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == ST_IDLE))
        else $error("run continues after its final pin state");

    a_nibble_only_4bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_nibble) |-> i_stat.four_bit)
        else $error("low nibble phase in 8-bit mode");
`endif

endmodule
`default_nettype wire

[rtl/char_lcd_bus_sequencer_unit.sv]
`default_nettype none
// A request is taken while the sequencer is idle; its pin states are then registered
// into the output register, one pin state per cycle while the sink keeps up.
// No new request is taken until the final pin state of the run has been emitted;
// requests that emit nothing leave the sequencer idle, ready for the next one.
// Reset (synchronous, active low): 4-bit bus, strobe hold 2 ms, driven pins 0,
// output channel empty.
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_unit
// Character LCD bus sequencer: turns requests into runs of timed pin states.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire  [7:0] i_cfg_wdata,
    clbs_req_if.sink   i_req,
    clbs_pin_if.source o_pin
);
    import clbs_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    clbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    clbs_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (i_req.opcode),
        .i_value        (i_req.value),
        .i_line         (i_req.line),
        .i_column       (i_req.column),
        .i_glyph_slot   (i_req.glyph_slot),
        .i_pin_ready    (o_pin.ready),
        .o_pin_valid    (o_pin.valid),
        .o_reg_select   (o_pin.reg_select),
        .o_bus_value    (o_pin.bus_value),
        .o_enable_level (o_pin.enable_level),
        .o_hold_ms      (o_pin.hold_ms),
        .o_last         (o_pin.last)
    );

endmodule
`default_nettype wire

[tb/char_lcd_bus_sequencer_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_unit_tb
// Self-checking bench for the LCD bus sequencer. A table of directed requests
// runs at reset settings. Random requests then run under several bus-mode and
// strobe-hold settings. Every request is predicted into a run of pin states
// when it is accepted. Each pin state that leaves the block is checked against
// the oldest prediction. Both channels idle at random, and once the pin side
// holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer_unit_tb;
    import clbs_pkg::*;

    localparam int          CYCLE_LIMIT     = 1_200_000;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          DRAIN_CYCLES    = 4;
    localparam int          DIR_N           = 21;
    localparam int          PHASE_N         = 7;
    localparam int          ITEMS_PER_PHASE = 30;

    localparam logic [2:0]  OP_UNUSED6      = 3'd6;
    localparam logic [2:0]  OP_UNUSED7      = 3'd7;

    localparam logic [7:0]  CMD_FUNC8       = 8'h38;
    localparam logic [7:0]  CMD_FUNC4       = 8'h28;
    localparam logic [7:0]  CMD_DISPLAY_ON  = 8'h0C;
    localparam logic [7:0]  CMD_CLEAR       = 8'h01;
    localparam logic [7:0]  CMD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0]  CMD_ROW0        = 8'h80;
    localparam logic [7:0]  CMD_ROW1        = 8'hC0;
    localparam logic [7:0]  CMD_CGRAM       = 8'h40;
    localparam logic [7:0]  CMD_HOME        = 8'h02;
    localparam logic [7:0]  MS_POWER_ON     = 8'd50;
    localparam logic [7:0]  MS_SHORT        = 8'd1;
    localparam logic [7:0]  MS_AFTER_CLEAR  = 8'd20;

    // per phase: bus mode and strobe hold, phase 0 in the low bits
    localparam logic [PHASE_N-1:0]   PH_MODE = 7'b1101010;
    localparam logic [8*PHASE_N-1:0] PH_HOLD = {8'd2, 8'd1, 8'd0, 8'd0,
                                                8'd255, 8'd255, 8'd1};
    localparam int                   PRESSURE_PHASE = 2;

    typedef struct packed {
        logic       rs;
        logic [7:0] bus;
        logic       en;
        logic [7:0] hold;
        logic       last;
    } t_lcd_pin;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] value;
        logic [1:0] line;
        logic [5:0] column;
        logic [2:0] slot;
        logic       typed;
        logic [2:0] n_pins;
    } t_dir_row;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [7:0] cfg_wdata;

    clbs_req_if req_ch ();
    clbs_pin_if pin_ch ();

    char_lcd_bus_sequencer_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_ch),
        .o_pin      (pin_ch)
    );

    // predictor copy of configuration and driven pins
    logic       lcd_mode_4bit;
    logic [7:0] lcd_strobe_ms;
    logic       lcd_rs_q;
    logic [7:0] lcd_bus_q;

    t_lcd_pin   seq_pins[$];
    t_lcd_pin   pin_expect[$];
    t_lcd_pin   typed_pins[0:3];
    t_dir_row   dir_tab[0:DIR_N-1];

    logic       cur_typed;
    logic [2:0] cur_n_pins;
    logic       sender_gaps;
    logic       sink_stalls;
    logic       holdoff_req;
    int         fails;
    int         cycle_cnt;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void pause_pins(input logic [7:0] ms);
        t_lcd_pin p;
        p = '{rs: lcd_rs_q, bus: lcd_bus_q, en: 1'b0, hold: ms, last: 1'b0};
        seq_pins.push_back(p);
    endfunction

    function automatic void strobe_pins(input logic rs, input logic [7:0] b);
        t_lcd_pin p;
        lcd_rs_q  = rs;
        lcd_bus_q = b;
        p = '{rs: rs, bus: b, en: 1'b1, hold: lcd_strobe_ms, last: 1'b0};
        seq_pins.push_back(p);
        p.en = 1'b0;
        seq_pins.push_back(p);
    endfunction

    function automatic void byte_pins(input logic rs, input logic [7:0] b);
        if (lcd_mode_4bit) begin
            strobe_pins(rs, {b[7:4], 4'h0});
            strobe_pins(rs, {b[3:0], 4'h0});
        end else begin
            strobe_pins(rs, b);
        end
    endfunction

    // fill seq_pins with the pin states one request causes
    function automatic void predict_request(input logic [2:0] op, input logic [7:0] value,
                                            input logic [1:0] line, input logic [5:0] column,
                                            input logic [2:0] slot);
        t_lcd_pin p;
        seq_pins.delete();
        case (op)
            OP_INIT: begin
                pause_pins(MS_POWER_ON);
                if (lcd_mode_4bit) begin
                    byte_pins(1'b0, CMD_HOME);
                    pause_pins(MS_SHORT);
                    byte_pins(1'b0, CMD_FUNC4);
                end else begin
                    byte_pins(1'b0, CMD_FUNC8);
                end
                pause_pins(MS_SHORT);
                byte_pins(1'b0, CMD_DISPLAY_ON);
                pause_pins(MS_SHORT);
                byte_pins(1'b0, CMD_CLEAR);
                pause_pins(MS_AFTER_CLEAR);
                byte_pins(1'b0, CMD_ENTRY_MODE);
                byte_pins(1'b0, CMD_ROW0);
            end
            OP_CMD:   byte_pins(1'b0, value);
            OP_DATA:  byte_pins(1'b1, value);
            OP_GOTO: begin
                if (column <= 6'd15) begin
                    if (line == 2'd0) begin
                        byte_pins(1'b0, CMD_ROW0 + {2'b00, column});
                    end else if (line == 2'd1) begin
                        byte_pins(1'b0, CMD_ROW1 + {2'b00, column});
                    end
                end
            end
            OP_CLEAR: byte_pins(1'b0, CMD_CLEAR);
            OP_GLYPH: byte_pins(1'b0, CMD_CGRAM + {2'b00, slot, 3'b000});
            default: ;
        endcase
        if (seq_pins.size() > 0) begin
            p = seq_pins.pop_back();
            p.last = 1'b1;
            seq_pins.push_back(p);
        end
    endfunction

    function automatic int gap_len();
        int r;
        if (!sender_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // offer one request; returns on the falling edge after the transfer
    task automatic send_item(input logic [2:0] op, input logic [7:0] value,
                             input logic [1:0] line, input logic [5:0] column,
                             input logic [2:0] slot, input logic typed,
                             input logic [2:0] n_pins, input int gap);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.opcode     = op;
        req_ch.value      = value;
        req_ch.line       = line;
        req_ch.column     = column;
        req_ch.glyph_slot = slot;
        cur_typed         = typed;
        cur_n_pins        = n_pins;
        req_ch.valid      = 1'b1;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [7:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_BUS_MODE) lcd_mode_4bit = data[0];
        else lcd_strobe_ms = data;
    endtask

    task automatic wait_idle();
        while (pin_expect.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // pin side: random stalls, or a long hold-off on request
    initial begin : pin_sink
        int r;
        int stall_left;
        stall_left   = 0;
        pin_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holdoff_req) begin
                pin_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                holdoff_req = 1'b0;
            end else if (!sink_stalls) begin
                pin_ch.ready = 1'b1;
            end else if (stall_left > 0) begin
                pin_ch.ready = 1'b0;
                stall_left--;
            end else begin
                pin_ch.ready = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 20) stall_left = $urandom_range(1, 3);
                else if (r < 24) stall_left = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk) begin : pin_check
        t_lcd_pin want;
        if (rst_n && req_ch.valid && req_ch.ready) begin
            predict_request(req_ch.opcode, req_ch.value, req_ch.line, req_ch.column,
                            req_ch.glyph_slot);
            if (cur_typed) begin
                for (int i = 0; i < cur_n_pins; i++) pin_expect.push_back(typed_pins[i]);
            end else begin
                foreach (seq_pins[i]) pin_expect.push_back(seq_pins[i]);
            end
        end
        if (rst_n && pin_ch.valid && pin_ch.ready) begin
            if (pin_expect.size() == 0) begin
                $error("unexpected pin state: rs %0d bus %h en %0d hold %0d last %0d",
                       pin_ch.reg_select, pin_ch.bus_value, pin_ch.enable_level,
                       pin_ch.hold_ms, pin_ch.last);
                fails++;
            end else begin
                want = pin_expect.pop_front();
                if (pin_ch.reg_select !== want.rs) begin
                    $error("reg_select: expected %0d, got %0d", want.rs, pin_ch.reg_select);
                    fails++;
                end
                if (pin_ch.bus_value !== want.bus) begin
                    $error("bus_value: expected %h, got %h", want.bus, pin_ch.bus_value);
                    fails++;
                end
                if (pin_ch.enable_level !== want.en) begin
                    $error("enable_level: expected %0d, got %0d", want.en,
                           pin_ch.enable_level);
                    fails++;
                end
                if (pin_ch.hold_ms !== want.hold) begin
                    $error("hold_ms: expected %0d, got %0d", want.hold, pin_ch.hold_ms);
                    fails++;
                end
                if (pin_ch.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, pin_ch.last);
                    fails++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [2:0] op;
        logic [7:0] value;
        logic [1:0] line;
        logic [5:0] column;
        logic [2:0] slot;
        int         pick;
        int         emitted;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_BUS_MODE;
        cfg_wdata         = 8'h00;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = OP_INIT;
        req_ch.value      = 8'h00;
        req_ch.line       = 2'd0;
        req_ch.column     = 6'd0;
        req_ch.glyph_slot = 3'd0;
        cur_typed         = 1'b0;
        cur_n_pins        = 3'd0;
        sender_gaps       = 1'b1;
        sink_stalls       = 1'b1;
        holdoff_req       = 1'b0;
        fails             = 0;
        cycle_cnt         = 0;

        lcd_mode_4bit = BUS_MODE_RST;
        lcd_strobe_ms = STROBE_HOLD_RST;
        lcd_rs_q      = 1'b0;
        lcd_bus_q     = 8'h00;

        // clear at reset settings: 4-bit, 2 ms strobes, 0x01 as two nibbles
        typed_pins[0] = '{1'b0, 8'h00, 1'b1, 8'd2, 1'b0};
        typed_pins[1] = '{1'b0, 8'h00, 1'b0, 8'd2, 1'b0};
        typed_pins[2] = '{1'b0, 8'h10, 1'b1, 8'd2, 1'b0};
        typed_pins[3] = '{1'b0, 8'h10, 1'b0, 8'd2, 1'b1};

        //               op          value  line  col    slot  typed n
        dir_tab[0]  = '{OP_INIT,    8'h00, 2'd0, 6'd0,  3'd0, 1'b0, 3'd0};
        dir_tab[1]  = '{OP_CLEAR,   8'h00, 2'd0, 6'd0,  3'd0, 1'b1, 3'd4};
        dir_tab[2]  = '{OP_CMD,     8'h00, 2'd0, 6'd0,  3'd0, 1'b0, 3'd0};
        dir_tab[3]  = '{OP_CMD,     8'hFF, 2'd3, 6'd63, 3'd7, 1'b0, 3'd0};
        dir_tab[4]  = '{OP_DATA,    8'h00, 2'd0, 6'd0,  3'd0, 1'b0, 3'd0};
        dir_tab[5]  = '{OP_DATA,    8'hFF, 2'd3, 6'd63, 3'd7, 1'b0, 3'd0};
        dir_tab[6]  = '{OP_DATA,    8'h5A, 2'd1, 6'd21, 3'd2, 1'b0, 3'd0};
        dir_tab[7]  = '{OP_GOTO,    8'h00, 2'd0, 6'd0,  3'd0, 1'b0, 3'd0};
        dir_tab[8]  = '{OP_GOTO,    8'hFF, 2'd0, 6'd15, 3'd7, 1'b0, 3'd0};
        dir_tab[9]  = '{OP_GOTO,    8'h00, 2'd1, 6'd0,  3'd0, 1'b0, 3'd0};
        dir_tab[10] = '{OP_GOTO,    8'hFF, 2'd1, 6'd15, 3'd7, 1'b0, 3'd0};
        // rows and columns off the display: nothing comes out
        dir_tab[11] = '{OP_GOTO,    8'h00, 2'd2, 6'd0,  3'd0, 1'b1, 3'd0};
        dir_tab[12] = '{OP_GOTO,    8'hFF, 2'd3, 6'd63, 3'd7, 1'b1, 3'd0};
        dir_tab[13] = '{OP_GOTO,    8'h00, 2'd0, 6'd16, 3'd0, 1'b1, 3'd0};
        dir_tab[14] = '{OP_GOTO,    8'h00, 2'd1, 6'd63, 3'd0, 1'b1, 3'd0};
        dir_tab[15] = '{OP_GLYPH,   8'h00, 2'd0, 6'd0,  3'd0, 1'b0, 3'd0};
        dir_tab[16] = '{OP_GLYPH,   8'hFF, 2'd3, 6'd63, 3'd7, 1'b0, 3'd0};
        // unused codes: nothing out, driven pins untouched
        dir_tab[17] = '{OP_UNUSED6, 8'hFF, 2'd3, 6'd63, 3'd7, 1'b1, 3'd0};
        dir_tab[18] = '{OP_UNUSED7, 8'h00, 2'd0, 6'd0,  3'd0, 1'b1, 3'd0};
        // the first init pause after a data byte repeats RS high and its last bus value
        dir_tab[19] = '{OP_DATA,    8'hA5, 2'd0, 6'd0,  3'd0, 1'b0, 3'd0};
        dir_tab[20] = '{OP_INIT,    8'hFF, 2'd3, 6'd63, 3'd7, 1'b0, 3'd0};

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        for (int k = 0; k < DIR_N; k++) begin
            send_item(dir_tab[k].op, dir_tab[k].value, dir_tab[k].line, dir_tab[k].column,
                      dir_tab[k].slot, dir_tab[k].typed, dir_tab[k].n_pins, gap_len());
        end
        req_ch.valid = 1'b0;
        wait_idle();

        for (int p = 0; p < PHASE_N; p++) begin
            write_cfg(CFG_BUS_MODE, {7'd0, PH_MODE[p]});
            write_cfg(CFG_STROBE_HOLD, PH_HOLD[p*8 +: 8]);
            sink_stalls = (p % 3 != 0);
            sender_gaps = (p % 3 != 0) && (p != PRESSURE_PHASE);
            if (p == PRESSURE_PHASE) holdoff_req = 1'b1;
            emitted = 0;
            while (emitted < ITEMS_PER_PHASE) begin
                pick   = $urandom_range(0, 99);
                value  = $urandom_range(0, 255);
                line   = $urandom_range(0, 3);
                column = $urandom_range(0, 63);
                slot   = $urandom_range(0, 7);
                if (pick < 8) op = OP_INIT;
                else if (pick < 28) op = OP_CMD;
                else if (pick < 50) op = OP_DATA;
                else if (pick < 70) op = OP_GOTO;
                else if (pick < 80) op = OP_CLEAR;
                else if (pick < 93) op = OP_GLYPH;
                else if (pick < 97) op = OP_UNUSED6;
                else op = OP_UNUSED7;
                // keep most go-to requests on the display
                if (op == OP_GOTO && $urandom_range(0, 3) != 0) begin
                    line   = $urandom_range(0, 1);
                    column = $urandom_range(0, 15);
                end
                send_item(op, value, line, column, slot, 1'b0, 3'd0, gap_len());
                if (op <= OP_GLYPH && !(op == OP_GOTO && (line > 2'd1 || column > 6'd15)))
                    emitted++;
            end
            req_ch.valid = 1'b0;
            wait_idle();
        end

        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
